FILE: src/gss_pkg.sv
// Shared types and constants for the Gauss-Seidel solver core.
package gss_pkg;

  localparam logic [1:0] OP_LOAD_MAT = 2'd0;
  localparam logic [1:0] OP_LOAD_VEC = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_PIV  = 2'd2;

  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_SWEEP = 2'd2;

  // datapath commands
  typedef struct packed {
    logic acc_init;   // acc <= rhs << 16, capture old
    logic acc_sub;    // acc -= A*u for the product in flight
    logic mul_go;     // register product of current operand read
    logic div_start;  // launch divider
    logic upd;        // write quotient, accumulate squared change
    logic norm_clr;
    logic piv_chk;    // test diagonal read data
    logic piv_clr;
  } gss_cmd_t;

  typedef struct packed {
    logic div_done;
    logic piv_zero;
    logic norm_ok;
  } gss_sts_t;

endpackage

FILE: src/gss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/gss_div.sv
// Radix-2 restoring divider: 64-bit signed dividend by 32-bit signed divisor,
// truncated quotient saturated to 32 bits.
module gss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [32:0] shl;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    shl = {rem_r[31:0], q_r[63]};
    trial = {1'b0, shl} - {2'b0, d_r};
    if (start) begin
      q_nxt   = num[63] ? 64'(-num) : num;
      d_nxt   = den[31] ? 32'(-den) : den;
      neg_nxt = num[63] ^ den[31];
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shl;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  // magnitude fits 64 bits unsigned; saturate to signed 32
  always_comb begin
    if (neg_r) quo = (q_r > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q_r);
    else       quo = (q_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_r);
  end
  assign done = done_r;
endmodule

FILE: src/gss_datapath.sv
// Datapath: stores, multiply-accumulate, divider and change norm.
module gss_datapath #(
  parameter int MAX_UNKNOWNS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gss_pkg::gss_cmd_t       cmd,
  output gss_pkg::gss_sts_t       sts,
  input  logic [62:0]             tol,
  // store write (loads and update)
  input  logic                    mat_we,
  input  logic [2*$clog2(MAX_UNKNOWNS)-1:0] mat_waddr,
  input  logic [31:0]             mat_wdata,
  input  logic                    vec_we,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0] vec_waddr,
  input  logic [31:0]             rhs_wdata,
  input  logic [31:0]             sol_wdata,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0] row,
  input  logic [2*$clog2(MAX_UNKNOWNS)-1:0] mat_raddr,
  input  logic [$clog2(MAX_UNKNOWNS)-1:0] sol_raddr,
  output logic [31:0]             sol_rdata
);
  localparam int AW = $clog2(MAX_UNKNOWNS);
  localparam int MW = 2*AW;  // matrix addressed as {row, col}
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

  logic [31:0] mat_rd, rhs_rd, sol_rd;
  logic signed [63:0] prod_r, acc_r, acc_nxt, diff;
  logic signed [31:0] old_r, piv_r, quo;
  logic [63:0] norm_r, norm_nxt, sq_r;
  logic [32:0] ad;
  logic        sq_v_r, piv_zero_r, div_done;
  logic        s_we;
  logic [AW-1:0] s_wa;
  logic [31:0]   s_wd;

  assign s_we = vec_we | cmd.upd;
  assign s_wa = cmd.upd ? row : vec_waddr;
  assign s_wd = cmd.upd ? quo : sol_wdata;

  gss_ram #(.WIDTH(32), .DEPTH(1 << MW)) u_mat (
    .clk, .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rd));
  gss_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_rhs (
    .clk, .we(vec_we), .waddr(vec_waddr), .wdata(rhs_wdata),
    .raddr(row), .rdata(rhs_rd));
  gss_ram #(.WIDTH(32), .DEPTH(MAX_UNKNOWNS)) u_sol (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
    .raddr(sol_raddr), .rdata(sol_rd));
  assign sol_rdata = sol_rd;

  gss_div u_div (.clk, .rst_n, .start(cmd.div_start), .num(acc_r), .den(piv_r),
    .done(div_done), .quo(quo));

  // saturating product subtract, change and norm sum
  always_comb begin
    acc_nxt = acc_r - prod_r;
    if (prod_r > 0 && acc_r < ACC_MIN + prod_r) acc_nxt = ACC_MIN;
    if (prod_r < 0 && acc_r > ACC_MAX + prod_r) acc_nxt = ACC_MAX;
    diff = 64'(old_r) - 64'(quo);
    ad = diff[63] ? 33'(-diff) : 33'(diff);
    norm_nxt = (norm_r > ~sq_r) ? '1 : norm_r + sq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= '0; sq_v_r <= 1'b0; piv_zero_r <= 1'b0;
    end else begin
      sq_v_r <= cmd.upd;
      if (cmd.norm_clr) norm_r <= '0;
      else if (sq_v_r) norm_r <= norm_nxt;
      if (cmd.piv_clr) piv_zero_r <= 1'b0;
      else if (cmd.piv_chk && mat_rd == '0) piv_zero_r <= 1'b1;
    end
    if (cmd.mul_go) prod_r <= $signed(mat_rd) * $signed(sol_rd);
    if (cmd.acc_init) begin
      acc_r <= {{16{rhs_rd[31]}}, rhs_rd, 16'd0};
      old_r <= sol_rd;
      piv_r <= mat_rd;
    end else if (cmd.acc_sub) acc_r <= acc_nxt;
    if (cmd.upd) sq_r <= 64'(ad) * 64'(ad);
  end

  assign sts.div_done = div_done;
  assign sts.piv_zero = piv_zero_r;
  assign sts.norm_ok  = norm_r <= {1'b0, tol};
endmodule

FILE: src/gss_ctrl.sv
// Controller: pivot check, sweep sequencing and result emission.
module gss_ctrl #(
  parameter int MAX_UNKNOWNS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [4:0]           n,
  input  logic [15:0]          max_sweeps,
  input  gss_pkg::gss_sts_t    sts,
  output gss_pkg::gss_cmd_t    cmd,
  output logic [$clog2(MAX_UNKNOWNS)-1:0] row,
  output logic [2*$clog2(MAX_UNKNOWNS)-1:0] mat_raddr,
  output logic [$clog2(MAX_UNKNOWNS)-1:0] sol_raddr,
  output logic                 emit_valid,
  input  logic                 emit_ready,
  output logic                 emit_last,
  output logic [1:0]           status,
  output logic [15:0]          sweeps
);
  localparam int AW = $clog2(MAX_UNKNOWNS);
  localparam int MW = 2*AW;
  localparam logic [3:0] S_IDLE = 4'd0, S_PIV = 4'd1, S_PIVW = 4'd2,
    S_ROW = 4'd3, S_INIT = 4'd4, S_MAC = 4'd5, S_DRAIN = 4'd6,
    S_DIV = 4'd7, S_UPD = 4'd8, S_NORM = 4'd9, S_CHK = 4'd10,
    S_ERD = 4'd11, S_EMIT = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [AW:0]   i_r, i_nxt, j_r, j_nxt;
  logic [15:0]   sw_r, sw_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          pv_r, pv_nxt, pv2_r, pv2_nxt; // product pipe valid
  logic [AW:0]   nm1;

  assign nm1 = (AW+1)'(n - 5'd1);
  assign row = i_r[AW-1:0];

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; sw_nxt = sw_r; stat_nxt = stat_r;
    pv_nxt = 1'b0; pv2_nxt = pv_r;
    cmd = '0;
    mat_raddr = MW'({i_r[AW-1:0], i_r[AW-1:0]});
    sol_raddr = i_r[AW-1:0];
    cmd.acc_sub = pv2_r;
    cmd.mul_go  = pv_r;
    case (st_r)
      S_IDLE: if (start) begin
        i_nxt = '0; sw_nxt = '0; cmd.piv_clr = 1'b1; st_nxt = S_PIV;
      end
      S_PIV: begin // diag read issued; checked next cycle
        pv_nxt = 1'b1;
        if (i_r == nm1) st_nxt = S_PIVW;
        else i_nxt = i_r + 1'b1;
      end
      S_PIVW: if (!pv_r) begin
        i_nxt = '0;
        if (sts.piv_zero) begin stat_nxt = gss_pkg::ST_ZERO_PIV; st_nxt = S_ERD; end
        else begin cmd.norm_clr = 1'b1; st_nxt = S_ROW; end
      end
      S_ROW: st_nxt = S_INIT; // diag, rhs, old read in flight
      S_INIT: begin cmd.acc_init = 1'b1; j_nxt = '0; st_nxt = S_MAC; end
      S_MAC: begin
        mat_raddr = MW'({i_r[AW-1:0], j_r[AW-1:0]});
        sol_raddr = j_r[AW-1:0];
        pv_nxt = (j_r != i_r);
        if (j_r == nm1) st_nxt = S_DRAIN;
        else j_nxt = j_r + 1'b1;
      end
      S_DRAIN: if (!pv_r && !pv2_r) begin cmd.div_start = 1'b1; st_nxt = S_DIV; end
      S_DIV: if (sts.div_done) begin cmd.upd = 1'b1; st_nxt = S_NORM; end
      S_NORM: st_nxt = S_UPD; // squared change lands in norm
      S_UPD: begin
        if (i_r == nm1) begin sw_nxt = sw_r + 16'd1; st_nxt = S_CHK; end
        else begin i_nxt = i_r + 1'b1; st_nxt = S_ROW; end
      end
      S_CHK: begin
        i_nxt = '0;
        if (sts.norm_ok) begin stat_nxt = gss_pkg::ST_CONVERGED; st_nxt = S_ERD; end
        else if (sw_r >= max_sweeps) begin stat_nxt = gss_pkg::ST_LIMIT; st_nxt = S_ERD; end
        else begin cmd.norm_clr = 1'b1; st_nxt = S_ROW; end
      end
      S_ERD: st_nxt = S_EMIT;
      S_EMIT: if (emit_ready) begin
        if (i_r == nm1) st_nxt = S_IDLE;
        else begin i_nxt = i_r + 1'b1; st_nxt = S_ERD; end
      end
      default: st_nxt = S_IDLE;
    endcase
    // pivot pipe reuses pv_r as a one-cycle marker for its read
    if (st_r == S_PIVW || st_r == S_PIV) begin
      cmd.piv_chk = pv_r; cmd.mul_go = 1'b0; cmd.acc_sub = 1'b0; pv2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; sw_r <= '0; stat_r <= '0;
      pv_r <= 1'b0; pv2_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; sw_r <= sw_nxt;
      stat_r <= stat_nxt; pv_r <= pv_nxt; pv2_r <= pv2_nxt;
    end
  end

  assign busy       = st_r != S_IDLE;
  assign emit_valid = st_r == S_EMIT;
  assign emit_last  = i_r == nm1;
  assign status     = stat_r;
  assign sweeps     = sw_r;
endmodule

FILE: src/gauss_seidel_solver_core.sv
// Gauss-Seidel solver core: Q16.16 fixed point, controller plus datapath.
// Loads: one beat per cycle while no run is in flight, no results. Start: pivot
// check, then sweeps (n-term multiply-accumulate, 64-step divider per row),
// then n result beats. Next item accepted once the run drains. Reset (rst_n low,
// synchronous) restores control and config registers to defaults and idles the
// controller; matrix, rhs and solution stores hold undefined data until loaded.
module gauss_seidel_solver_core #(
  parameter int MAX_UNKNOWNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // row[3:0] col[7:4] value[39:8] guess[71:40]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // index[3:0] solution[35:4] sweeps_done[51:36], pad
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int AW = $clog2(MAX_UNKNOWNS);
  localparam int MW = 2*AW;
  localparam logic [4:0] SIZE_CAP = (MAX_UNKNOWNS < 16) ? 5'(MAX_UNKNOWNS) : 5'd16;

  logic [4:0]  size_r;
  logic [62:0] tol_r;
  logic [15:0] maxsw_r;
  logic [4:0]  n;
  logic [15:0] maxsw_eff;

  logic [1:0]  op;
  logic [3:0]  f_row, f_col;
  logic [31:0] f_value, f_guess;
  logic        acc, busy, in_range_r, in_range_c;

  gss_pkg::gss_cmd_t cmd;
  gss_pkg::gss_sts_t sts;
  logic [AW-1:0] row, sol_raddr;
  logic [MW-1:0] mat_raddr;
  logic [31:0]   sol_rdata;
  logic          emit_valid, emit_last;
  logic [1:0]    status;
  logic [15:0]   sweeps;

  assign op      = in_tuser;
  assign f_row   = in_tdata[3:0];
  assign f_col   = in_tdata[7:4];
  assign f_value = in_tdata[39:8];
  assign f_guess = in_tdata[71:40];

  // loads go straight to the stores; a start hands off to the controller
  assign in_tready = !busy;
  assign acc       = in_tvalid && in_tready;
  assign in_range_r = 32'(f_row) < MAX_UNKNOWNS;
  assign in_range_c = 32'(f_col) < MAX_UNKNOWNS;

  // active size clamps to 1..SIZE_CAP, sweep limit 0 acts as 1
  assign n = (size_r == 5'd0) ? 5'd1 : (size_r > SIZE_CAP) ? SIZE_CAP : size_r;
  assign maxsw_eff = (maxsw_r == 16'd0) ? 16'd1 : maxsw_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 5'd16; tol_r <= 63'd4294967; maxsw_r <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gss_pkg::CFG_SIZE:  size_r  <= cfg_data[4:0];
        gss_pkg::CFG_TOL:   tol_r   <= cfg_data[62:0];
        gss_pkg::CFG_SWEEP: maxsw_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gss_ctrl #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_ctrl (
    .clk, .rst_n, .start(acc && op == gss_pkg::OP_START), .busy,
    .n, .max_sweeps(maxsw_eff), .sts, .cmd, .row, .mat_raddr, .sol_raddr,
    .emit_valid, .emit_ready(out_tready), .emit_last, .status, .sweeps);

  gss_datapath #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .tol(tol_r),
    .mat_we(acc && op == gss_pkg::OP_LOAD_MAT && in_range_r && in_range_c),
    .mat_waddr({AW'(f_row), AW'(f_col)}), .mat_wdata(f_value),
    .vec_we(acc && op == gss_pkg::OP_LOAD_VEC && in_range_r),
    .vec_waddr(AW'(f_row)), .rhs_wdata(f_value), .sol_wdata(f_guess),
    .row, .mat_raddr, .sol_raddr, .sol_rdata);

  // result beat: solution read registered in the RAM, held while stalled
  assign out_tvalid = emit_valid;
  assign out_tdata  = {4'd0, sweeps, sol_rdata, 4'(row)};
  assign out_tlast  = emit_last;
  assign out_tuser  = status;

  // no input beat while a run is in flight
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken during solve");
  // result beats only while a run is active
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy) else $error("result outside run");
  // zero-pivot results report no sweeps
  a_piv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gss_pkg::ST_ZERO_PIV) |-> out_tdata[51:36] == 16'd0)
    else $error("sweeps on zero pivot");
endmodule

FILE: tb/gauss_seidel_solver_core_tb.sv
// Gauss-Seidel core testbench: directed and random phases checked against a built-in predictor.
module gauss_seidel_solver_core_tb;

  localparam int N_MAX = 16;
  localparam longint ACC_HI = 64'sh7fff_ffff_ffff_ffff;
  localparam longint ACC_LO = -64'sh7fff_ffff_ffff_ffff;
  localparam logic [62:0] TOL_TOP = {63{1'b1}};
  localparam logic [1:0] OP_IGNORED = 2'd3;  // opcode the block drops

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
    logic [31:0] guess;
  } gs_item_t;

  typedef struct {
    logic [3:0]  index;
    logic [31:0] solution;
    logic        last;
    logic [1:0]  status;
    logic [15:0] sweeps;
  } gs_elem_t;

  // Solver shadow: holds its own stores and registers, queues expected
  // solution beats on each start beat.
  class solve_scoreboard;
    logic signed [31:0] mat[N_MAX][N_MAX];
    logic signed [31:0] rhs[N_MAX];
    logic signed [31:0] sol[N_MAX];
    logic [4:0]  n_reg;
    logic [62:0] tol_reg;
    logic [15:0] sweep_lim;
    gs_elem_t    pending[$];
    int          errors;

    function new();
      n_reg = 5'd16;
      tol_reg = 63'd4294967;
      sweep_lim = 16'd1000;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        gss_pkg::CFG_SIZE:  n_reg = data[4:0];
        gss_pkg::CFG_TOL:   tol_reg = data[62:0];
        gss_pkg::CFG_SWEEP: sweep_lim = data[15:0];
        default: ;
      endcase
    endfunction

    function longint sub_sat(longint a, longint b);
      if (b > 0 && a < ACC_LO + b) return ACC_LO;
      if (b < 0 && a > ACC_HI + b) return ACC_HI;
      return a - b;
    endfunction

    function void note_input(gs_item_t it);
      int n, sweeps;
      logic [1:0] st;
      longint acc, q, d;
      logic signed [31:0] old, nw;
      logic [63:0] norm, ad, sq;
      gs_elem_t e;
      case (it.op)
        gss_pkg::OP_LOAD_MAT: mat[it.row][it.col] = it.value;
        gss_pkg::OP_LOAD_VEC: begin
          rhs[it.row] = it.value;
          sol[it.row] = it.guess;
        end
        gss_pkg::OP_START: begin
          n = (n_reg == 0) ? 1 : (n_reg > N_MAX) ? N_MAX : int'(n_reg);
          st = gss_pkg::ST_CONVERGED;
          sweeps = 0;
          for (int i = 0; i < n; i++)
            if (mat[i][i] == 0) st = gss_pkg::ST_ZERO_PIV;
          if (st != gss_pkg::ST_ZERO_PIV) begin
            do begin
              norm = 0;
              for (int i = 0; i < n; i++) begin
                acc = longint'(rhs[i]) * 65536;
                old = sol[i];
                for (int j = 0; j < n; j++)
                  if (j != i) acc = sub_sat(acc, longint'(mat[i][j]) * longint'(sol[j]));
                q = acc / longint'(mat[i][i]);
                nw = (q > 64'sd2147483647) ? 32'sh7fffffff :
                     (q < -64'sd2147483648) ? 32'sh80000000 : q[31:0];
                sol[i] = nw;
                d = longint'(old) - longint'(nw);
                ad = (d < 0) ? -d : d;
                sq = ad * ad;
                norm = (norm > ~sq) ? {64{1'b1}} : norm + sq;
              end
              sweeps++;
            end while (norm > {1'b0, tol_reg} && sweeps < int'(sweep_lim));
            st = (norm <= {1'b0, tol_reg}) ? gss_pkg::ST_CONVERGED : gss_pkg::ST_LIMIT;
          end
          for (int i = 0; i < n; i++) begin
            e.index = 4'(i);
            e.solution = sol[i];
            e.last = (i == n - 1);
            e.status = st;
            e.sweeps = 16'(sweeps);
            pending.push_back(e);
          end
        end
        default: ;  // unused opcode, dropped by the block
      endcase
    endfunction

    function void check(gs_elem_t got);
      gs_elem_t exp_e;
      if (pending.size() == 0) begin
        $error("unexpected solution beat, index %0d", got.index);
        errors++;
        return;
      end
      exp_e = pending.pop_front();
      if (got.index !== exp_e.index) begin
        $error("index: expected %0d, got %0d", exp_e.index, got.index); errors++;
      end
      if (got.solution !== exp_e.solution) begin
        $error("solution: expected %h, got %h", exp_e.solution, got.solution); errors++;
      end
      if (got.last !== exp_e.last) begin
        $error("last: expected %0d, got %0d", exp_e.last, got.last); errors++;
      end
      if (got.status !== exp_e.status) begin
        $error("status: expected %0d, got %0d", exp_e.status, got.status); errors++;
      end
      if (got.sweeps !== exp_e.sweeps) begin
        $error("sweeps_done: expected %0d, got %0d", exp_e.sweeps, got.sweeps); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  solve_scoreboard sb = new();
  bit  idle_off;       // long stretch with no idling on either side
  bit  hold_req;       // asks the receiver for a long hold-off
  int  items_sent;

  gauss_seidel_solver_core i_dut (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random backpressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      out_tready <= 1'b0;
      hold_req = 1'b0;
      repeat (3000) @(posedge clk);
    end else begin
      out_tready <= rst_n && (idle_off || $urandom_range(99) >= 21);
    end
  end

  // Result monitor; DUT outputs are read before this edge's updates land.
  always @(posedge clk) begin
    gs_elem_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.index    = out_tdata[3:0];
      got.solution = out_tdata[35:4];
      got.sweeps   = out_tdata[51:36];
      got.last     = out_tlast;
      got.status   = out_tuser;
      sb.check(got);
    end
  end

  task automatic send_beat(gs_item_t it);
    while (!idle_off && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.guess, it.value, it.col, it.row};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
    if (it.op != OP_IGNORED) items_sent++;
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Sender pauses until the last solution beat is out, then lets the
  // controller settle before touching registers.
  task automatic drain_run();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit tame, bit diag, int n);
    int sel;
    if (tame) begin
      if (diag) return ($urandom_range(1) ? 1 : -1) * (n * 65536 + $urandom_range(65535));
      return $urandom_range(65535) - 32768;
    end
    sel = $urandom_range(7);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0001;
      3, 4, 5: return $urandom;
      default: return $urandom_range(1 << 19) - (1 << 18);
    endcase
  endfunction

  // Ignored opcode or a load outside the active rows: both leave the
  // active system untouched.
  task automatic send_noise(int n);
    gs_item_t it;
    it.value = $urandom;
    it.guess = $urandom;
    it.row = 4'($urandom);
    it.col = 4'($urandom);
    if (n < N_MAX && $urandom_range(1)) begin
      it.op = $urandom_range(1) ? gss_pkg::OP_LOAD_MAT : gss_pkg::OP_LOAD_VEC;
      it.row = 4'($urandom_range(N_MAX - 1, n));
    end else begin
      it.op = OP_IGNORED;
    end
    send_beat(it);
  endtask

  // When reload is set, load the whole active system in random order; then start.
  task automatic solve_system(int n, bit tame, bit reload);
    gs_item_t it;
    int slots[$];
    int k, s;
    if (reload) begin
      for (int i = 0; i < n * n + n; i++) slots.push_back(i);
      slots.shuffle();
      foreach (slots[m]) begin
        s = slots[m];
        if ($urandom_range(9) == 0) send_noise(n);
        if (s < n * n) begin
          it.op  = gss_pkg::OP_LOAD_MAT;
          it.row = 4'(s / n);
          it.col = 4'(s % n);
          it.value = pick_value(tame, it.row == it.col, n);
          if (it.row == it.col && $urandom_range(11) == 0) it.value = '0;
          it.guess = $urandom;
        end else begin
          k = s - n * n;
          it.op  = gss_pkg::OP_LOAD_VEC;
          it.row = 4'(k);
          it.col = 4'($urandom);
          it.value = tame ? $urandom_range(1 << 20) - (1 << 19) : pick_value(0, 0, n);
          it.guess = tame ? $urandom_range(1 << 20) - (1 << 19) : pick_value(0, 0, n);
        end
        send_beat(it);
      end
    end
    it.op = gss_pkg::OP_START;
    it.row = 4'($urandom);
    it.col = 4'($urandom);
    it.value = $urandom;
    it.guess = $urandom;
    send_beat(it);
  endtask

  task automatic run_phase(logic [4:0] size, logic [63:0] tol, logic [15:0] lim,
                           bit tame, int runs);
    int n;
    drain_run();
    write_cfg(gss_pkg::CFG_SIZE, {59'd0, size});
    write_cfg(gss_pkg::CFG_TOL, tol);
    write_cfg(gss_pkg::CFG_SWEEP, {48'd0, lim});
    cfg_valid <= 1'b0;
    n = (size == 0) ? 1 : (size > N_MAX) ? N_MAX : int'(size);
    for (int r = 0; r < runs; r++)
      solve_system(n, tame, r == 0 || $urandom_range(4) != 0);
  endtask

  initial begin
    logic [4:0]  size;
    logic [63:0] tol;
    int pick;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= gss_pkg::OP_LOAD_MAT;
    cfg_valid  <= 1'b0;
    cfg_index  <= gss_pkg::CFG_SIZE;
    cfg_data   <= '0;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: one unknown with a zero sweep limit and zero
    // tolerance, size zero with the top limit and loosest tolerance.
    run_phase(5'd1, 64'd0, 16'd0, 0, 2);
    run_phase(5'd0, 64'hffff_ffff_ffff_ffff, 16'hffff, 1, 2);
    // Full size under a long receiver hold-off; the second run's first beat
    // is offered while the first run is stuck at the output.
    hold_req = 1'b1;
    run_phase(5'd16, 64'd4294967, 16'd1, 0, 2);
    idle_off = 1'b1;
    run_phase(5'd31, {1'b0, TOL_TOP}, 16'd2, 1, 1);
    run_phase(5'd3, 64'd0, 16'd3, 0, 3);
    idle_off = 1'b0;

    while (items_sent < 520) begin
      pick = $urandom_range(7);
      size = (pick == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6, 1));
      if ($urandom_range(1)) begin
        tol = $urandom_range(1) ? 64'h7fff_ffff_ffff_ffff : {$urandom, $urandom} >> 20;
        run_phase(size, tol, 16'($urandom_range(32, 1)), 1, $urandom_range(3, 1));
      end else begin
        tol = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom);
        run_phase(size, tol, 16'($urandom_range(4)), 0, $urandom_range(3, 1));
      end
    end

    drain_run();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("gauss_seidel_solver_core_tb passed");
    else
      $display("gauss_seidel_solver_core_tb failed");
    $finish;
  end

  initial begin
    #400000000;
    $display("gauss_seidel_solver_core_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
src/gss_pkg.sv
src/gss_ram.sv
src/gss_div.sv
src/gss_datapath.sv
src/gss_ctrl.sv
src/gauss_seidel_solver_core.sv
tb/gauss_seidel_solver_core_tb.sv
